// ===== sv/fbsc_pkg.sv =====
// Package: shared types, codes and constants of the frustum cull block.
`default_nettype none
package fbsc_pkg;

    localparam int MAX_PLANES = 6;
    localparam int PLANE_IDX_W = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W = $clog2(MAX_PLANES + 1);
    localparam int PROD_W = 65;
    localparam int ACC_W = 68;

    // item modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_SPHERE = 2'd1;
    localparam logic [1:0] MODE_BOX = 2'd2;

    // configuration register indexes and reset values
    localparam logic REG_PLANES_TESTED = 1'b0;
    localparam logic [2:0] PLANES_TESTED_RESET = 3'd5;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [32:0] sum_t;

    typedef struct packed {
        coord_t a;
        coord_t b;
        coord_t c;
        coord_t d;
    } plane_t;

endpackage
`default_nettype wire

// ===== sv/fbsc_in_if.sv =====
// Interface: request channel carrying plane loads and shape tests.
`default_nettype none
interface fbsc_in_if;
    logic valid;
    logic ready;
    logic [1:0] mode;
    logic [2:0] plane_index;
    fbsc_pkg::coord_t px;
    fbsc_pkg::coord_t py;
    fbsc_pkg::coord_t pz;
    fbsc_pkg::coord_t pw;
    fbsc_pkg::coord_t min_x;
    fbsc_pkg::coord_t min_y;
    fbsc_pkg::coord_t min_z;
    fbsc_pkg::coord_t max_x;
    fbsc_pkg::coord_t max_y;
    fbsc_pkg::coord_t max_z;

    modport source (
        output valid, mode, plane_index, px, py, pz, pw,
        output min_x, min_y, min_z, max_x, max_y, max_z,
        input ready
    );
    modport sink (
        input valid, mode, plane_index, px, py, pz, pw,
        input min_x, min_y, min_z, max_x, max_y, max_z,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/fbsc_out_if.sv =====
// Interface: result channel carrying the visibility flag.
`default_nettype none
interface fbsc_out_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input ready
    );
    modport sink (
        input valid, visible,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/frustum_box_sphere_cull.sv =====
// Top level: frustum culling of spheres and boxes against stored planes.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+---------------------------------------------
//  in_ch    | in  | valid/ready     | mode, plane_index, px..pw, min_*, max_*
//  out_ch   | out | valid/ready     | visible
//  apb      | in  | psel/penable    | planes_tested at address 0
//
// A load or an unknown mode is taken and gives no result.
// A test is accepted, then for each tested plane the block runs a row fetch,
// three multiplies on the single 32x33 multiplier and a sign check, stopping at
// the first plane that culls; a done state then moves the result out.
// rst_n clears control state and sets planes_tested to 5; plane contents stay unknown.
// in_ch.ready is low while a test runs or its result cannot yet be handed out.
`default_nettype none
module frustum_box_sphere_cull (
    input  wire logic        clk,
    input  wire logic        rst_n,
    fbsc_in_if.sink          in_ch,
    fbsc_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_CHK   = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    fbsc_pkg::plane_t plane_mem [fbsc_pkg::MAX_PLANES];
    fbsc_pkg::plane_t row_reg;

    logic [2:0] planes_tested_reg;

    logic [fbsc_pkg::PLANE_IDX_W-1:0] plane_reg, plane_next;
    logic [fbsc_pkg::CNT_W-1:0] n_reg, n_next;
    logic [1:0] k_reg, k_next;
    logic vis_reg, vis_next;
    logic box_reg;

    fbsc_pkg::sum_t sum_lo_reg [3];
    fbsc_pkg::sum_t sum_hi_reg [3];
    logic [2:0] hi_lt_lo_reg;
    fbsc_pkg::sum_t ext_reg;

    logic signed [fbsc_pkg::PROD_W-1:0] prod_reg;
    logic signed [fbsc_pkg::ACC_W-1:0] acc_reg;

    logic out_valid_reg, out_visible_reg;

    logic in_fire;
    logic is_test;
    logic [fbsc_pkg::CNT_W-1:0] n_in;
    fbsc_pkg::sum_t in_lo [3];
    fbsc_pkg::sum_t in_hi [3];
    fbsc_pkg::coord_t in_o [3];
    fbsc_pkg::coord_t in_mn [3];
    fbsc_pkg::coord_t in_mx [3];

    fbsc_pkg::coord_t a_sel;
    fbsc_pkg::sum_t op_sel;
    logic signed [fbsc_pkg::PROD_W-1:0] prod_next;
    logic signed [33:0] dext;
    logic signed [fbsc_pkg::ACC_W-1:0] acc_init;
    logic signed [fbsc_pkg::ACC_W-1:0] acc_step;
    logic signed [fbsc_pkg::ACC_W-1:0] total;
    logic out_load;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            planes_tested_reg <= fbsc_pkg::PLANES_TESTED_RESET;
        end
        else if (psel && penable && pwrite && (paddr[2] == fbsc_pkg::REG_PLANES_TESTED))
        begin
            planes_tested_reg <= pwdata[2:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == fbsc_pkg::REG_PLANES_TESTED)
        begin
            prdata = {29'd0, planes_tested_reg};
        end
    end

    // ---------------- input decode ----------------
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire = in_ch.valid && in_ch.ready;
    assign is_test = (in_ch.mode == fbsc_pkg::MODE_SPHERE) || (in_ch.mode == fbsc_pkg::MODE_BOX);

    assign n_in = ({1'b0, planes_tested_reg} > 4'(fbsc_pkg::MAX_PLANES))
                  ? fbsc_pkg::CNT_W'(fbsc_pkg::MAX_PLANES)
                  : fbsc_pkg::CNT_W'(planes_tested_reg);

    assign in_o[0] = in_ch.px;
    assign in_o[1] = in_ch.py;
    assign in_o[2] = in_ch.pz;
    assign in_mn[0] = in_ch.min_x;
    assign in_mn[1] = in_ch.min_y;
    assign in_mn[2] = in_ch.min_z;
    assign in_mx[0] = in_ch.max_x;
    assign in_mx[1] = in_ch.max_y;
    assign in_mx[2] = in_ch.max_z;

    // corner coordinates per axis; a sphere uses its centre for both
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (in_ch.mode == fbsc_pkg::MODE_BOX)
            begin
                in_lo[i] = {in_o[i][31], in_o[i]} + {in_mn[i][31], in_mn[i]};
                in_hi[i] = {in_o[i][31], in_o[i]} + {in_mx[i][31], in_mx[i]};
            end
            else
            begin
                in_lo[i] = {in_o[i][31], in_o[i]};
                in_hi[i] = {in_o[i][31], in_o[i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_test)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sum_lo_reg[i] <= in_lo[i];
                sum_hi_reg[i] <= in_hi[i];
                hi_lt_lo_reg[i] <= (in_mx[i] < in_mn[i]);
            end
            box_reg <= (in_ch.mode == fbsc_pkg::MODE_BOX);
            ext_reg <= (in_ch.mode == fbsc_pkg::MODE_BOX)
                       ? 33'sd0 : {in_ch.pw[31], in_ch.pw};
        end
    end

    // ---------------- plane store ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire && (in_ch.mode == fbsc_pkg::MODE_LOAD)
            && ({1'b0, in_ch.plane_index} < 4'(fbsc_pkg::MAX_PLANES)))
        begin
            plane_mem[in_ch.plane_index[fbsc_pkg::PLANE_IDX_W-1:0]] <=
                '{a: in_ch.px, b: in_ch.py, c: in_ch.pz, d: in_ch.pw};
        end
        if (state_reg == ST_FETCH)
        begin
            row_reg <= plane_mem[plane_reg];
        end
    end

    // ---------------- shared multiply / accumulate ----------------
    always_comb
    begin
        a_sel = row_reg.a;
        unique case (k_reg)
            2'd0: a_sel = row_reg.a;
            2'd1: a_sel = row_reg.b;
            2'd2: a_sel = row_reg.c;
            default: a_sel = row_reg.a;
        endcase
    end

    // box: take the corner that maximizes a*m on this axis
    always_comb
    begin
        op_sel = sum_lo_reg[k_reg];
        if (box_reg && (a_sel[31] == hi_lt_lo_reg[k_reg]))
        begin
            op_sel = sum_hi_reg[k_reg];
        end
    end

    assign prod_next = fbsc_pkg::PROD_W'(a_sel) * fbsc_pkg::PROD_W'(op_sel);
    assign dext = {{2{row_reg.d[31]}}, row_reg.d} + {ext_reg[32], ext_reg};
    assign acc_init = {{18{dext[33]}}, dext, 16'd0};
    assign acc_step = acc_reg + {{3{prod_reg[fbsc_pkg::PROD_W-1]}}, prod_reg};
    assign total = acc_step;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_next;
            if (k_reg == 2'd0)
            begin
                acc_reg <= acc_init;
            end
            else
            begin
                acc_reg <= acc_step;
            end
        end
    end

    // ---------------- sequencer ----------------
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        n_next = n_reg;
        k_next = k_reg;
        vis_next = vis_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && is_test)
                begin
                    n_next = n_in;
                    plane_next = '0;
                    k_next = 2'd0;
                    vis_next = 1'b1;
                    state_next = (n_in == '0) ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                k_next = 2'd0;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = ST_CHK;
                end
                else
                begin
                    k_next = k_reg + 2'd1;
                end
            end
            ST_CHK:
            begin
                if (total[fbsc_pkg::ACC_W-1])
                begin
                    vis_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if ((fbsc_pkg::CNT_W'(plane_reg) + 1'b1) == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            plane_reg <= '0;
            n_reg <= '0;
            k_reg <= 2'd0;
            vis_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            plane_reg <= plane_next;
            n_reg <= n_next;
            k_reg <= k_next;
            vis_reg <= vis_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_visible_reg <= vis_reg;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.visible = out_visible_reg;

    // ---------------- assertions ----------------
    a_plane_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH || state_reg == ST_MUL || state_reg == ST_CHK)
        |-> (fbsc_pkg::CNT_W'(plane_reg) < n_reg))
        else $error("plane counter beyond tested planes");

    a_test_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && is_test) |=> (state_reg != ST_IDLE))
        else $error("accepted test did not start");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) |-> (k_reg != 2'd3))
        else $error("term counter out of range");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after completion");

endmodule
`default_nettype wire
